### rtl/json_tokenizer_top_defines.svh
// Assertion macros for the JSON tokenizer RTL.
// Used by json_tokenizer_top; no other dependencies.
`ifndef JSON_TOKENIZER_TOP_DEFINES_SVH
`define JSON_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication
`define JT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/jtok_pkg.sv
// Shared types, codes and lookup functions of the JSON tokenizer.
// No dependencies; imported by json_tokenizer_top.
package jtok_pkg;

	localparam int COUNTER_BITS_DEF = 24;
	localparam int OUT_BITS         = 24;
	localparam int FIFO_DEPTH       = 4;	// power of two

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_t;

	typedef struct packed {
		logic [3:0]          token_kind;
		logic [OUT_BITS-1:0] token_line;
		logic [OUT_BITS-1:0] token_column;
		logic [OUT_BITS-1:0] token_length;
		logic                last_of_run;
	} token_t;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_KEYWORD = 4'b0010,
		MODE_STRING  = 4'b0100,
		MODE_NUMBER  = 4'b1000
	} mode_t;

	// token kinds
	localparam logic [3:0] KIND_END     = 4'd0;
	localparam logic [3:0] KIND_LBRACE  = 4'd1;
	localparam logic [3:0] KIND_RBRACE  = 4'd2;
	localparam logic [3:0] KIND_LBRACK  = 4'd3;
	localparam logic [3:0] KIND_RBRACK  = 4'd4;
	localparam logic [3:0] KIND_COMMA   = 4'd5;
	localparam logic [3:0] KIND_COLON   = 4'd6;
	localparam logic [3:0] KIND_TRUE    = 4'd7;
	localparam logic [3:0] KIND_STRING  = 4'd10;
	localparam logic [3:0] KIND_INTEGER = 4'd11;
	localparam logic [3:0] KIND_FLOAT   = 4'd12;
	localparam logic [3:0] KIND_ERROR   = 4'd13;

	// number phases
	localparam logic [2:0] PH_SIGN    = 3'd0;
	localparam logic [2:0] PH_INT     = 3'd1;
	localparam logic [2:0] PH_POINT   = 3'd2;
	localparam logic [2:0] PH_EXP     = 3'd3;
	localparam logic [2:0] PH_EXPDIG  = 3'd4;
	localparam logic [2:0] PH_FRAC    = 3'd5;
	localparam logic [2:0] PH_EXPSIGN = 3'd6;

	// number step outcomes beyond a plain phase
	localparam logic [3:0] NX_BAD  = 4'd7;
	localparam logic [3:0] NX_TERM = 4'd8;

	// keyword kinds
	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	// characters
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_UPPER_E = 8'h45;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_L      = 8'h6C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// expected letter after the first one of a keyword
	function automatic logic [7:0] kw_char(input logic [1:0] kk, input logic [1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (kk)
			KW_TRUE: begin
				case (pos)
					2'd0:    c = CH_R;
					2'd1:    c = CH_U;
					2'd2:    c = CH_E;
					default: c = 8'h00;
				endcase
			end
			KW_FALSE: begin
				case (pos)
					2'd0:    c = CH_A;
					2'd1:    c = CH_L;
					2'd2:    c = CH_S;
					default: c = CH_E;
				endcase
			end
			default: begin
				case (pos)
					2'd0:    c = CH_U;
					2'd1:    c = CH_L;
					2'd2:    c = CH_L;
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [2:0] kw_total(input logic [1:0] kk);
		return (kk == KW_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [3:0] num_next(input logic [2:0] ph, input logic [7:0] b);
		logic [3:0] nx;
		nx = NX_TERM;
		if (b inside {[CH_0:CH_9]}) begin
			if (ph == PH_SIGN)
				nx = {1'b0, PH_INT};
			else if (ph == PH_POINT)
				nx = {1'b0, PH_FRAC};
			else if (ph == PH_EXP || ph == PH_EXPSIGN)
				nx = {1'b0, PH_EXPDIG};
			else
				nx = {1'b0, ph};
		end else if (b == CH_POINT) begin
			nx = (ph == PH_INT) ? {1'b0, PH_POINT} : NX_BAD;
		end else if (b inside {CH_PLUS, CH_MINUS}) begin
			nx = (ph == PH_EXP) ? {1'b0, PH_EXPSIGN} : NX_BAD;
		end else if (b inside {CH_E, CH_UPPER_E}) begin
			nx = (ph inside {PH_INT, PH_POINT, PH_FRAC}) ? {1'b0, PH_EXP} : NX_BAD;
		end
		return nx;
	endfunction

	function automatic logic [3:0] num_finish(input logic [2:0] ph);
		logic [3:0] k;
		if (ph == PH_INT)
			k = KIND_INTEGER;
		else if (ph == PH_FRAC || ph == PH_EXPDIG)
			k = KIND_FLOAT;
		else
			k = KIND_ERROR;
		return k;
	endfunction

endpackage

### rtl/json_tokenizer_top.sv
// JSON tokenizer: byte-serial lexer with a small result queue. Uses jtok_pkg.
// Each byte is registered in the input stage at acceptance; its results enter the queue
// when that stage fires. arst_n clears the control state, not the input byte or queued results.
// Throughput: one byte per cycle while the queue has room; a byte with two results uses
// two output beats; the four-beat queue stalls input only when it holds more than two.
`include "json_tokenizer_top_defines.svh"

module json_tokenizer_top import jtok_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   text_valid,
	output logic   text_stall,
	input  text_t  text,
	output logic   token_valid,
	input  logic   token_stall,
	output token_t token
);

	localparam int CB       = COUNTER_BITS;
	localparam int PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef logic [CB-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == '1) ? v : v + CB'(1);
	endfunction

	function automatic token_t mk_tok(input logic [3:0] kind, input cnt_t line,
			input cnt_t col, input cnt_t len);
		token_t t;
		t.token_kind   = kind;
		t.token_line   = OUT_BITS'(line);
		t.token_column = OUT_BITS'(col);
		t.token_length = OUT_BITS'(len);
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	// input stage
	logic  v_s1;
	text_t item_s1;
	logic  s1_go, fire;

	// lexer state
	mode_t      mode_q;
	logic [2:0] phase_q, kwp_q;
	logic [1:0] kwk_q;
	logic       esc_q, err_q;
	cnt_t       line_q, col_q, sline_q, scol_q, len_q;

	// result queue
	token_t              fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] fcnt_q;
	logic                pop;

	logic [7:0] b;
	assign b = item_s1.text_byte;

	// between-token decode
	mode_t      id_mode;
	logic [2:0] id_phase, id_kwp;
	logic [1:0] id_kwk;
	logic       id_esc, id_err, id_emit;
	logic [3:0] id_kind, id_punct;
	cnt_t       id_line, id_col, id_sline, id_scol, id_len;
	token_t     id_tok;

	always_comb begin
		case (b)
			CH_LBRACE: id_punct = KIND_LBRACE;
			CH_RBRACE: id_punct = KIND_RBRACE;
			CH_LBRACK: id_punct = KIND_LBRACK;
			CH_RBRACK: id_punct = KIND_RBRACK;
			CH_COMMA:  id_punct = KIND_COMMA;
			CH_COLON:  id_punct = KIND_COLON;
			default:   id_punct = KIND_END;
		endcase

		id_mode  = MODE_IDLE;
		id_line  = line_q;
		id_col   = col_q;
		id_sline = sline_q;
		id_scol  = scol_q;
		id_len   = len_q;
		id_kwk   = kwk_q;
		id_kwp   = kwp_q;
		id_phase = phase_q;
		id_esc   = esc_q;
		id_err   = err_q;
		id_emit  = 1'b0;
		id_kind  = KIND_ERROR;

		if (b == CH_NL) begin
			id_line = sat_inc(line_q);
			id_col  = CB'(1);
		end else if (b inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR}) begin
			id_col = sat_inc(col_q);
		end else if (id_punct != KIND_END) begin
			id_emit = 1'b1;
			id_kind = id_punct;
			id_col  = sat_inc(col_q);
		end else if (b inside {CH_T, CH_F, CH_N}) begin
			id_mode  = MODE_KEYWORD;
			id_sline = line_q;
			id_scol  = col_q;
			id_len   = CB'(1);
			id_col   = sat_inc(col_q);
			id_kwk   = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE : KW_NULL;
			id_kwp   = 3'd0;
		end else if (b == CH_QUOTE) begin
			id_mode  = MODE_STRING;
			id_sline = line_q;
			id_scol  = col_q;
			id_len   = '0;
			id_col   = sat_inc(col_q);
			id_esc   = 1'b0;
		end else if (b inside {[CH_0:CH_9], CH_PLUS, CH_MINUS}) begin
			id_mode  = MODE_NUMBER;
			id_sline = line_q;
			id_scol  = col_q;
			id_len   = CB'(1);
			id_col   = sat_inc(col_q);
			id_phase = (b inside {[CH_0:CH_9]}) ? PH_INT : PH_SIGN;
		end else begin
			id_emit = 1'b1;
			id_col  = sat_inc(col_q);
			id_err  = 1'b1;
		end
	end

	assign id_tok = mk_tok(id_kind, line_q, col_q, CB'(1));

	// main step
	logic [1:0] kk;
	logic [7:0] want;
	logic [3:0] nxp, fin;
	cnt_t       len_inc, col_inc;

	assign kk      = (kwk_q > KW_NULL) ? KW_NULL : kwk_q;
	assign want    = kw_char(kk, kwp_q[1:0]);
	assign nxp     = num_next(phase_q, b);
	assign fin     = num_finish(phase_q);
	assign len_inc = sat_inc(len_q);
	assign col_inc = sat_inc(col_q);

	mode_t      nx_mode;
	logic [2:0] nx_phase, nx_kwp;
	logic [1:0] nx_kwk;
	logic       nx_esc, nx_err;
	cnt_t       nx_line, nx_col, nx_sline, nx_scol, nx_len;
	token_t     r0, r1, end_tok;
	logic [1:0] nres;
	logic       pend;

	always_comb begin
		nx_mode  = mode_q;
		nx_phase = phase_q;
		nx_kwp   = kwp_q;
		nx_kwk   = kwk_q;
		nx_esc   = esc_q;
		nx_err   = err_q;
		nx_line  = line_q;
		nx_col   = col_q;
		nx_sline = sline_q;
		nx_scol  = scol_q;
		nx_len   = len_q;
		r0       = '0;
		r1       = '0;
		nres     = 2'd0;
		pend     = 1'b0;
		end_tok  = mk_tok(KIND_END, line_q, col_q, '0);

		if (item_s1.end_of_text) begin
			if (!err_q && mode_q == MODE_NUMBER) begin
				r0   = mk_tok(fin, sline_q, scol_q, len_q);
				pend = 1'b1;
			end else if (!err_q && (mode_q == MODE_KEYWORD || mode_q == MODE_STRING)) begin
				r0   = mk_tok(KIND_ERROR, sline_q, scol_q, len_q);
				pend = 1'b1;
			end
			if (pend) begin
				r1   = end_tok;
				nres = 2'd2;
			end else begin
				r0   = end_tok;
				nres = 2'd1;
			end
			// back to the reset state for the next text
			nx_mode  = MODE_IDLE;
			nx_phase = PH_SIGN;
			nx_kwp   = 3'd0;
			nx_kwk   = KW_TRUE;
			nx_esc   = 1'b0;
			nx_err   = 1'b0;
			nx_line  = CB'(1);
			nx_col   = CB'(1);
			nx_sline = CB'(1);
			nx_scol  = CB'(1);
			nx_len   = '0;
		end else if (!err_q) begin
			case (mode_q)
				MODE_KEYWORD: begin
					nx_col = col_inc;
					nx_len = len_inc;
					if (b != want) begin
						r0      = mk_tok(KIND_ERROR, sline_q, scol_q, len_inc);
						nres    = 2'd1;
						nx_err  = 1'b1;
						nx_mode = MODE_IDLE;
					end else begin
						nx_kwp = kwp_q + 3'd1;
						if (len_inc >= CB'(kw_total(kk))) begin
							r0      = mk_tok(KIND_TRUE + {2'b00, kk}, sline_q, scol_q, len_inc);
							nres    = 2'd1;
							nx_mode = MODE_IDLE;
						end
					end
				end
				MODE_STRING: begin
					nx_col = col_inc;
					if (esc_q) begin
						nx_esc = 1'b0;
						nx_len = len_inc;
					end else if (b == CH_QUOTE) begin
						r0      = mk_tok(KIND_STRING, sline_q, scol_q, len_q);
						nres    = 2'd1;
						nx_mode = MODE_IDLE;
					end else begin
						nx_len = len_inc;
						if (b == CH_BSLASH)
							nx_esc = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (nxp == NX_TERM) begin
						if (fin == KIND_ERROR) begin
							nx_col  = col_inc;
							r0      = mk_tok(KIND_ERROR, sline_q, scol_q, len_inc);
							nres    = 2'd1;
							nx_err  = 1'b1;
							nx_mode = MODE_IDLE;
						end else begin
							// the terminating byte starts whatever follows
							r0       = mk_tok(fin, sline_q, scol_q, len_q);
							nx_mode  = id_mode;
							nx_phase = id_phase;
							nx_kwp   = id_kwp;
							nx_kwk   = id_kwk;
							nx_esc   = id_esc;
							nx_err   = id_err;
							nx_line  = id_line;
							nx_col   = id_col;
							nx_sline = id_sline;
							nx_scol  = id_scol;
							nx_len   = id_len;
							if (id_emit) begin
								r1   = id_tok;
								nres = 2'd2;
							end else begin
								nres = 2'd1;
							end
						end
					end else begin
						nx_col = col_inc;
						nx_len = len_inc;
						if (nxp == NX_BAD) begin
							r0      = mk_tok(KIND_ERROR, sline_q, scol_q, len_inc);
							nres    = 2'd1;
							nx_err  = 1'b1;
							nx_mode = MODE_IDLE;
						end else begin
							nx_phase = nxp[2:0];
						end
					end
				end
				default: begin
					nx_mode  = id_mode;
					nx_phase = id_phase;
					nx_kwp   = id_kwp;
					nx_kwk   = id_kwk;
					nx_esc   = id_esc;
					nx_err   = id_err;
					nx_line  = id_line;
					nx_col   = id_col;
					nx_sline = id_sline;
					nx_scol  = id_scol;
					nx_len   = id_len;
					if (id_emit) begin
						r0   = id_tok;
						nres = 2'd1;
					end
				end
			endcase
		end

		if (nres == 2'd1)
			r0.last_of_run = 1'b1;
		r1.last_of_run = 1'b1;
	end

	// handshakes: room for two beats lets the input stage advance
	assign s1_go      = (fcnt_q <= CNT_BITS'(FIFO_DEPTH - 2));
	assign fire       = v_s1 && s1_go;
	assign text_stall = v_s1 && !s1_go;
	assign token_valid = (fcnt_q != '0);
	assign token       = fifo_q[rd_ptr_q];
	assign pop         = token_valid && !token_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall)
			item_s1 <= text;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			phase_q <= PH_SIGN;
			kwp_q   <= 3'd0;
			kwk_q   <= KW_TRUE;
			esc_q   <= 1'b0;
			err_q   <= 1'b0;
			line_q  <= CB'(1);
			col_q   <= CB'(1);
			sline_q <= CB'(1);
			scol_q  <= CB'(1);
			len_q   <= '0;
		end else if (fire) begin
			mode_q  <= nx_mode;
			phase_q <= nx_phase;
			kwp_q   <= nx_kwp;
			kwk_q   <= nx_kwk;
			esc_q   <= nx_esc;
			err_q   <= nx_err;
			line_q  <= nx_line;
			col_q   <= nx_col;
			sline_q <= nx_sline;
			scol_q  <= nx_scol;
			len_q   <= nx_len;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && nres != 2'd0)
			fifo_q[wr_ptr_q] <= r0;
		if (fire && nres == 2'd2)
			fifo_q[wr_ptr_q + PTR_BITS'(1)] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			if (fire)
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(nres);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			fcnt_q <= fcnt_q + CNT_BITS'(fire ? nres : 2'd0) - CNT_BITS'(pop);
		end
	end

	`JT_ASSERT_NOW(a_err_quiet, clk, arst_n, fire && err_q && !item_s1.end_of_text, nres == 2'd0, "result after latched error")
	`JT_ASSERT_NEXT(a_eot_reset, clk, arst_n, fire && item_s1.end_of_text, mode_q == MODE_IDLE && line_q == CB'(1) && col_q == CB'(1) && !err_q, "state not reset after end of text")
	`JT_ASSERT_NOW(a_pos_nonzero, clk, arst_n, 1'b1, line_q != '0 && col_q != '0, "line or column reached zero")
	`JT_ASSERT_NOW(a_fifo_bound, clk, arst_n, 1'b1, fcnt_q <= CNT_BITS'(FIFO_DEPTH), "result queue overflow")

endmodule
